>>> sv/upn_pkg.sv
// ----------------------------------------------------------------------------
// upn_pkg
// shared types, character codes and helper functions for the path normalizer
// ----------------------------------------------------------------------------
package upn_pkg;

   // parser phases, one-hot
   typedef enum logic [5:0] {
      PH_LEAD = 6'b000001,
      PH_SEG  = 6'b000010,
      PH_ESC1 = 6'b000100,
      PH_ESC2 = 6'b001000,
      PH_TRIM = 6'b010000,
      PH_FAIL = 6'b100000
   } phase_type;

   // character codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   // default document appended to an empty result or a trailing slash
   localparam int          IndexLen  = 10;
   localparam logic [3:0]  IndexLast = 4'(IndexLen - 1);

   // pending results for one transaction, emitted in field order
   typedef struct packed {
      logic       slash_a;    // separator before a segment byte
      logic       byte_v;     // segment byte
      logic [7:0] byte_val;
      logic       slash_b;    // separator before the default document
      logic       index_v;    // default document
      logic       status_v;   // status-only closing result
      logic       status_acc;
   } desc_type;

   function automatic logic desc_any(desc_type d);
      return d.slash_a | d.byte_v | d.slash_b | d.index_v | d.status_v;
   endfunction

   function automatic logic [7:0] index_char(logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h69; // i
         4'd1:    c = 8'h6E; // n
         4'd2:    c = 8'h64; // d
         4'd3:    c = 8'h65; // e
         4'd4:    c = 8'h78; // x
         4'd5:    c = 8'h2E; // .
         4'd6:    c = 8'h68; // h
         4'd7:    c = 8'h74; // t
         4'd8:    c = 8'h6D; // m
         4'd9:    c = 8'h6C; // l
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // returns {valid, nibble}
   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

endpackage

>>> sv/upn_parser.sv
// ----------------------------------------------------------------------------
// upn_parser
// per-byte path state machine; produces the result list of each transaction
// ----------------------------------------------------------------------------
module upn_parser import upn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  logic [7:0] path_byte,
   input  logic       byte_present,
   input  logic       end_of_path,
   output desc_type   desc
);

   phase_type  phase_ff,  phase_in;
   logic [3:0] nibble_ff, nibble_in;
   logic [1:0] seg_len_ff, seg_len_in;
   logic       all_dots_ff, all_dots_in;
   logic       nonempty_ff, nonempty_in;

   logic       stop;
   logic [4:0] hex;
   logic [7:0] seg_ch;
   logic       seg_go;
   logic       dots;

   assign stop = (path_byte == CH_QUEST) || (path_byte == CH_HASH);
   assign hex  = hex_decode(path_byte);

   always_comb begin
      phase_in    = phase_ff;
      nibble_in   = nibble_ff;
      seg_len_in  = seg_len_ff;
      all_dots_in = all_dots_ff;
      nonempty_in = nonempty_ff;
      desc        = '0;
      seg_ch      = path_byte;
      seg_go      = 1'b0;
      dots        = 1'b0;

      if (byte_present) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (path_byte == CH_SLASH) begin
                  phase_in    = PH_SEG;
                  seg_len_in  = 2'd0;
                  all_dots_in = 1'b1;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_SEG: begin
               if (stop) begin
                  phase_in = PH_TRIM;
               end else if (path_byte == CH_PERCENT) begin
                  phase_in = PH_ESC1;
               end else if (path_byte == CH_SLASH) begin
                  if (all_dots_ff && (seg_len_ff == 2'd1 || seg_len_ff == 2'd2)) begin
                     phase_in = PH_FAIL;
                  end else begin
                     seg_len_in  = 2'd0;
                     all_dots_in = 1'b1;
                  end
               end else begin
                  seg_go = 1'b1;
               end
            end
            PH_ESC1: begin
               if (stop || !hex[4]) begin
                  phase_in = PH_FAIL;
               end else begin
                  nibble_in = hex[3:0];
                  phase_in  = PH_ESC2;
               end
            end
            PH_ESC2: begin
               seg_ch = {nibble_ff, hex[3:0]};
               if (stop || !hex[4] || seg_ch == CH_SLASH) begin
                  phase_in = PH_FAIL;
               end else begin
                  seg_go = 1'b1;
               end
            end
            PH_TRIM: begin
            end
            default: begin
               phase_in = PH_FAIL;
            end
         endcase

         // a byte that joins the current segment
         if (seg_go) begin
            if (seg_ch == CH_BSLASH || seg_ch == CH_COLON || seg_ch == CH_NUL) begin
               phase_in = PH_FAIL;
            end else begin
               desc.slash_a  = (seg_len_ff == 2'd0) && nonempty_ff;
               desc.byte_v   = 1'b1;
               desc.byte_val = seg_ch;
               nonempty_in   = 1'b1;
               if (seg_len_ff != 2'd3) begin
                  seg_len_in = seg_len_ff + 2'd1;
               end
               if (seg_ch != CH_DOT) begin
                  all_dots_in = 1'b0;
               end
               phase_in = PH_SEG;
            end
         end
      end

      if (end_of_path) begin
         dots = all_dots_in && (seg_len_in == 2'd1 || seg_len_in == 2'd2);
         if ((phase_in != PH_SEG && phase_in != PH_TRIM) || dots) begin
            desc.status_v   = 1'b1;
            desc.status_acc = 1'b0;
         end else if (!nonempty_in || seg_len_in == 2'd0) begin
            desc.slash_b = nonempty_in;
            desc.index_v = 1'b1;
         end else begin
            desc.status_v   = 1'b1;
            desc.status_acc = 1'b1;
         end
         phase_in    = PH_LEAD;
         nibble_in   = 4'd0;
         seg_len_in  = 2'd0;
         all_dots_in = 1'b1;
         nonempty_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEAD;
         nibble_ff   <= 4'd0;
         seg_len_ff  <= 2'd0;
         all_dots_ff <= 1'b1;
         nonempty_ff <= 1'b0;
      end else if (in_accept) begin
         phase_ff    <= phase_in;
         nibble_ff   <= nibble_in;
         seg_len_ff  <= seg_len_in;
         all_dots_ff <= all_dots_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

>>> sv/upn_emitter.sv
// ----------------------------------------------------------------------------
// upn_emitter
// holds a transaction's results; sends one per cycle when not stalled
// ----------------------------------------------------------------------------
module upn_emitter import upn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  desc_type   desc,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_present,
   output logic       rsp_last,
   output logic       rsp_accepted
);

   desc_type   desc_ff, desc_in, desc_taken;
   logic       pend_ff, pend_in, pend_taken;
   logic [3:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;
   logic [7:0] byte_ff, byte_in;
   logic       pres_ff, pres_in;
   logic       last_ff, last_in;
   logic       acc_ff, acc_in;
   logic       take;

   assign take = pend_ff && (!rv_ff || rsp_ready);

   always_comb begin
      desc_taken = desc_ff;
      cnt_in     = cnt_ff;
      rv_in      = rv_ff && !rsp_ready;
      byte_in    = byte_ff;
      pres_in    = pres_ff;
      last_in    = last_ff;
      acc_in     = acc_ff;

      if (take) begin
         rv_in   = 1'b1;
         byte_in = 8'd0;
         pres_in = 1'b1;
         last_in = 1'b0;
         acc_in  = 1'b0;
         if (desc_ff.slash_a) begin
            byte_in            = CH_SLASH;
            desc_taken.slash_a = 1'b0;
         end else if (desc_ff.byte_v) begin
            byte_in           = desc_ff.byte_val;
            desc_taken.byte_v = 1'b0;
         end else if (desc_ff.slash_b) begin
            byte_in            = CH_SLASH;
            desc_taken.slash_b = 1'b0;
         end else if (desc_ff.index_v) begin
            byte_in = index_char(cnt_ff);
            if (cnt_ff == IndexLast) begin
               last_in            = 1'b1;
               acc_in             = 1'b1;
               desc_taken.index_v = 1'b0;
               cnt_in             = 4'd0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end else begin
            pres_in             = 1'b0;
            last_in             = 1'b1;
            acc_in              = desc_ff.status_acc;
            desc_taken.status_v = 1'b0;
         end
      end

      pend_taken = pend_ff && desc_any(desc_taken);
      desc_in    = desc_taken;
      pend_in    = pend_taken;
      if (load && desc_any(desc)) begin
         desc_in = desc;
         pend_in = 1'b1;
         cnt_in  = 4'd0;
      end
   end

   assign free = !pend_taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         cnt_ff  <= 4'd0;
         rv_ff   <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      if (take) begin
         byte_ff <= byte_in;
         pres_ff <= pres_in;
         last_ff <= last_in;
         acc_ff  <= acc_in;
      end
   end

   assign rsp_valid    = rv_ff;
   assign rsp_byte     = byte_ff;
   assign rsp_present  = pres_ff;
   assign rsp_last     = last_ff;
   assign rsp_accepted = acc_ff;

endmodule

>>> sv/url_path_normalizer_core.sv
// ----------------------------------------------------------------------------
// url_path_normalizer_core
// streaming url path cleaner: percent decoding, segment checks, default doc
// ----------------------------------------------------------------------------
// output path: a transaction's first result enters the result list register and
//   moves on to the output register, where it is valid, once that is free or taken
// throughput: one transaction per cycle while each yields at most one result and
//   the receiver is ready; a transaction with several results holds the emitter
//   until all are sent (up to 11 when the default document is appended)
// reset: synchronous, active high; parser returns to expecting the leading slash
//   and the result list and output register are emptied
// ----------------------------------------------------------------------------
module url_path_normalizer_core import upn_pkg::*; (
   input  logic       clock,
   input  logic       reset,

   // request stream: one raw path byte per transaction
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] path_byte
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // end_of_path

   // response stream: one normalized byte or a status per transaction
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] out_present, [1] accepted
   output logic       rsp_tlast    // last_of_path
);

   desc_type desc;      // results caused by the current request transaction
   logic     req_take;
   logic     emit_free;

   // a request is taken whenever the emitter will have room for its results
   assign req_tready = emit_free;
   assign req_take   = req_tvalid && req_tready;

   // path state machine: decodes escapes, tracks segment shape, closes the path
   upn_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (req_take),
      .path_byte    (req_tdata),
      .byte_present (req_tuser),
      .end_of_path  (req_tlast),
      .desc         (desc)
   );

   // result list and output registers; drains one result per cycle unless stalled
   upn_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .load         (req_take),
      .desc         (desc),
      .free         (emit_free),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_byte     (rsp_tdata),
      .rsp_present  (rsp_tuser[0]),
      .rsp_last     (rsp_tlast),
      .rsp_accepted (rsp_tuser[1])
   );

   // accepted is only ever reported on the closing result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("accepted flag on a non-final result");

   // a status-only result always closes the path and carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("status-only result not final or carries data");

   // a successful close with a byte is always the last letter of the default doc
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && rsp_tlast) |->
         (rsp_tuser[1] && rsp_tdata == index_char(IndexLast)))
      else $error("final data result is not the end of the default document");

endmodule

>>> verif/url_path_normalizer_core_test.sv
// ----------------------------------------------------------------------------
// url_path_normalizer_core_test
// self-checking bench for the streaming url path cleaner: a directed table of
// corner paths, then random well-formed and broken paths under varying idle
// and stall patterns, every response transaction checked against a predictor
// ----------------------------------------------------------------------------
module url_path_normalizer_core_test;
   import upn_pkg::*;

   // one response transaction, fields in checking order
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
      logic       acc;
   } path_result_t;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic [7:0]   raw;
      logic         present;
      logic         last;
      logic         typed;
      path_result_t want;
   } stim_row_t;

   localparam path_result_t NO_RESULT       = '{data: CH_NUL, present: 1'b0,
                                                last: 1'b0, acc: 1'b0};
   localparam path_result_t REJECTED        = '{data: CH_NUL, present: 1'b0,
                                                last: 1'b1, acc: 1'b0};
   localparam path_result_t ACCEPTED_STATUS = '{data: CH_NUL, present: 1'b0,
                                                last: 1'b1, acc: 1'b1};

   localparam logic [8*IndexLen-1:0] DEFAULT_DOC = "index.html";

   localparam int DirectedLen   = 25;
   localparam int PhaseAEnd     = 140;   // accepted items at the end of each idle phase
   localparam int PhaseBEnd     = 250;
   localparam int TotalItems    = 370;
   localparam int HoldAt        = 300;   // long receiver hold-off starts here
   localparam int HoldCycles    = 150;
   localparam int DrainCycles   = 20;
   localparam int TimeoutUnits  = 400000;

   // corner paths: bad lead byte, empty path, mixed-case escapes with a
   // trailing slash, ".." before a '?', short escape, trim by '#' and an
   // end-only transaction closing an accepted path
   stim_row_t directed_rows [DirectedLen] = '{
      {CH_NUL,     1'b1, 1'b1, 1'b1, REJECTED},          // lead byte not a slash
      {CH_SLASH,   1'b1, 1'b1, 1'b0, NO_RESULT},         // empty path, default doc
      {CH_SLASH,   1'b1, 1'b0, 1'b0, NO_RESULT},
      {"a",        1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_PERCENT, 1'b1, 1'b0, 1'b0, NO_RESULT},
      {"4",        1'b1, 1'b0, 1'b0, NO_RESULT},
      {"1",        1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_SLASH,   1'b1, 1'b0, 1'b0, NO_RESULT},
      {8'hA5,      1'b0, 1'b0, 1'b0, NO_RESULT},         // idle transaction
      {CH_PERCENT, 1'b1, 1'b0, 1'b0, NO_RESULT},
      {"f",        1'b1, 1'b0, 1'b0, NO_RESULT},
      {"F",        1'b1, 1'b0, 1'b0, NO_RESULT},         // decodes to 0xff
      {CH_SLASH,   1'b1, 1'b1, 1'b0, NO_RESULT},         // trailing slash
      {CH_SLASH,   1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_DOT,     1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_DOT,     1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_QUEST,   1'b1, 1'b1, 1'b1, REJECTED},          // dot-dot segment
      {CH_SLASH,   1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_PERCENT, 1'b1, 1'b0, 1'b0, NO_RESULT},
      {"5",        1'b1, 1'b1, 1'b1, REJECTED},          // escape cut off by the end
      {CH_SLASH,   1'b1, 1'b0, 1'b0, NO_RESULT},
      {"z",        1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_HASH,    1'b1, 1'b0, 1'b0, NO_RESULT},
      {CH_COLON,   1'b1, 1'b0, 1'b0, NO_RESULT},         // swallowed after the trim
      {8'hFF,      1'b0, 1'b1, 1'b1, ACCEPTED_STATUS}    // end-only transaction
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;     // [7:0] path_byte
   logic       req_tuser;     // [0] byte_present
   logic       req_tlast;     // end_of_path
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;     // [7:0] out_byte
   logic [1:0] rsp_tuser;     // [0] out_present, [1] accepted
   logic       rsp_tlast;     // last_of_path

   // expected response transactions, oldest first
   path_result_t cleaned_path_q [$];

   int mismatch_count;
   int items_in;              // accepted transactions that carry a byte or an end
   int req_idle_pct;
   int rsp_idle_pct;

   // predictor state
   phase_type  cur_phase;
   logic [3:0] esc_high;
   logic [1:0] seg_len;       // saturates at three
   logic       seg_dots;
   logic       out_nonempty;

   url_path_normalizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // predictor
   // -------------------------------------------------------------------------

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         return int'(c - "a") + 10;
      end else if (c >= "A" && c <= "F") begin
         return int'(c - "A") + 10;
      end
      return -1;
   endfunction

   // a segment of one or two dots only
   function automatic logic seg_is_dots();
      return seg_dots && (seg_len == 2'd1 || seg_len == 2'd2);
   endfunction

   task automatic clear_path_state();
      cur_phase    = PH_LEAD;
      esc_high     = 4'd0;
      seg_len      = 2'd0;
      seg_dots     = 1'b1;
      out_nonempty = 1'b0;
   endtask

   task automatic emit(input logic [7:0] b, input logic p, input logic l, input logic a);
      path_result_t r;
      r = '{data: b, present: p, last: l, acc: a};
      cleaned_path_q.push_back(r);
   endtask

   // raw or decoded byte that lands in the current segment
   task automatic segment_char(input logic [7:0] c);
      if (c == CH_BSLASH || c == CH_COLON || c == CH_NUL) begin
         cur_phase = PH_FAIL;
      end else begin
         // separator goes out only ahead of the first byte of a later segment
         if (seg_len == 2'd0 && out_nonempty) begin
            emit(CH_SLASH, 1'b1, 1'b0, 1'b0);
         end
         emit(c, 1'b1, 1'b0, 1'b0);
         out_nonempty = 1'b1;
         if (seg_len != 2'd3) begin
            seg_len = seg_len + 2'd1;
         end
         if (c != CH_DOT) begin
            seg_dots = 1'b0;
         end
         cur_phase = PH_SEG;
      end
   endtask

   task automatic take_raw(input logic [7:0] b);
      logic       stop;
      int         nib;
      logic [7:0] dec;
      stop = (b == CH_QUEST || b == CH_HASH);
      nib  = hex_nibble(b);
      case (cur_phase)
         PH_LEAD: begin
            if (b == CH_SLASH) begin
               cur_phase = PH_SEG;
               seg_len   = 2'd0;
               seg_dots  = 1'b1;
            end else begin
               cur_phase = PH_FAIL;
            end
         end
         PH_SEG: begin
            if (stop) begin
               cur_phase = PH_TRIM;
            end else if (b == CH_PERCENT) begin
               cur_phase = PH_ESC1;
            end else if (b == CH_SLASH) begin
               if (seg_is_dots()) begin
                  cur_phase = PH_FAIL;
               end else begin
                  seg_len  = 2'd0;
                  seg_dots = 1'b1;
               end
            end else begin
               segment_char(b);
            end
         end
         PH_ESC1: begin
            if (stop || nib < 0) begin
               cur_phase = PH_FAIL;
            end else begin
               esc_high  = 4'(nib);
               cur_phase = PH_ESC2;
            end
         end
         PH_ESC2: begin
            dec = {esc_high, 4'(nib)};
            if (stop || nib < 0) begin
               cur_phase = PH_FAIL;
            end else if (dec == CH_SLASH || dec == CH_BSLASH || dec == CH_NUL) begin
               // escapes must not smuggle a separator or a nul
               cur_phase = PH_FAIL;
            end else begin
               segment_char(dec);
            end
         end
         PH_TRIM: begin
         end
         default: begin
            cur_phase = PH_FAIL;
         end
      endcase
   endtask

   // expected responses of one accepted request transaction
   task automatic normalize_item(input logic [7:0] b, input logic p, input logic e);
      int i;
      if (p) begin
         take_raw(b);
      end
      if (e) begin
         if ((cur_phase == PH_SEG || cur_phase == PH_TRIM) && seg_is_dots()) begin
            cur_phase = PH_FAIL;
         end
         if (cur_phase != PH_SEG && cur_phase != PH_TRIM) begin
            emit(CH_NUL, 1'b0, 1'b1, 1'b0);
         end else if (!out_nonempty || seg_len == 2'd0) begin
            // empty result or trailing slash: append the default document
            if (out_nonempty) begin
               emit(CH_SLASH, 1'b1, 1'b0, 1'b0);
            end
            for (i = 0; i < IndexLen; i++) begin
               emit(DEFAULT_DOC[8*(IndexLen-1-i) +: 8], 1'b1,
                    i == IndexLen - 1, i == IndexLen - 1);
            end
         end else begin
            emit(CH_NUL, 1'b0, 1'b1, 1'b1);
         end
         clear_path_state();
      end
   endtask

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // called and returning at a falling edge; each call assigns req_tvalid
   // at most once per time step
   task automatic send_item(input logic [7:0] b, input logic p, input logic e,
                            input logic typed, input path_result_t want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= p;
      req_tlast  <= e;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      normalize_item(b, p, e);
      if (typed) begin
         // status rows close the path with exactly one response
         void'(cleaned_path_q.pop_back());
         cleaned_path_q.push_back(want);
      end
      if (p || e) begin
         items_in++;
      end
      @(negedge clock);
   endtask

   // sender stays quiet until every expected response has arrived
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (cleaned_path_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'("0" + n);
      end
      return 8'(($urandom_range(1) != 0 ? "a" : "A") + n - 4'd10);
   endfunction

   // one random path: mostly well-formed with random content, some noise
   task automatic send_random_path();
      logic [8:0] items [$];    // {byte_present, path_byte}
      logic [7:0] c;
      int         nseg;
      int         len;
      int         s;
      int         k;
      int         r;
      logic       end_only;
      if ($urandom_range(99) < 8) begin
         // raw noise, usually failing on the lead byte
         len = $urandom_range(1, 8);
         for (k = 0; k < len; k++) begin
            items.push_back({1'b1, 8'($urandom_range(255))});
         end
      end else begin
         items.push_back({1'b1, CH_SLASH});
         nseg = $urandom_range(0, 3);
         for (s = 0; s < nseg; s++) begin
            if ($urandom_range(11) == 0) begin
               // dot segment
               len = $urandom_range(1, 2);
               for (k = 0; k < len; k++) begin
                  items.push_back({1'b1, CH_DOT});
               end
            end else begin
               len = $urandom_range(1, 4);
               for (k = 0; k < len; k++) begin
                  r = $urandom_range(99);
                  if (r < 50) begin
                     c = hex_char(4'($urandom_range(15)));
                     if ($urandom_range(1) != 0) begin
                        c = 8'("g" + $urandom_range(19));
                     end
                     items.push_back({1'b1, c});
                  end else if (r < 62) begin
                     items.push_back({1'b1, CH_DOT});
                  end else if (r < 80) begin
                     // well-formed escape, now and then of a forbidden byte
                     c = 8'($urandom_range(255));
                     if (r >= 78) begin
                        case ($urandom_range(2))
                           0:       c = CH_SLASH;
                           1:       c = CH_BSLASH;
                           default: c = CH_NUL;
                        endcase
                     end
                     items.push_back({1'b1, CH_PERCENT});
                     items.push_back({1'b1, hex_char(c[7:4])});
                     items.push_back({1'b1, hex_char(c[3:0])});
                  end else if (r < 83) begin
                     // malformed or short escape
                     items.push_back({1'b1, CH_PERCENT});
                     items.push_back({1'b1, 8'($urandom_range(255))});
                  end else if (r < 87) begin
                     case ($urandom_range(2))
                        0:       c = CH_COLON;
                        1:       c = CH_BSLASH;
                        default: c = CH_NUL;
                     endcase
                     items.push_back({1'b1, c});
                  end else begin
                     items.push_back({1'b1, 8'($urandom_range(255))});
                  end
               end
            end
            if (s < nseg - 1 || $urandom_range(2) == 0) begin
               items.push_back({1'b1, CH_SLASH});
            end
            if ($urandom_range(9) == 0) begin
               items.push_back({1'b1, CH_SLASH});   // empty segment
            end
         end
         if ($urandom_range(9) == 0) begin
            // query or fragment, then junk that must be swallowed
            items.push_back({1'b1, ($urandom_range(1) != 0) ? CH_QUEST : CH_HASH});
            len = $urandom_range(0, 3);
            for (k = 0; k < len; k++) begin
               items.push_back({1'b1, 8'($urandom_range(255))});
            end
         end
      end
      end_only = ($urandom_range(3) == 0);
      for (k = 0; k < items.size(); k++) begin
         if ($urandom_range(24) == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_RESULT);
         end
         send_item(items[k][7:0], items[k][8], !end_only && k == items.size() - 1,
                   1'b0, NO_RESULT);
      end
      if (end_only) begin
         send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_RESULT);
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'd0;
      req_tuser      = 1'b0;
      req_tlast      = 1'b0;
      mismatch_count = 0;
      items_in       = 0;
      req_idle_pct   = 16;
      rsp_idle_pct   = 58;
      clear_path_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DirectedLen; i++) begin
         send_item(directed_rows[i].raw, directed_rows[i].present, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
      end
      while (items_in < PhaseAEnd) begin
         send_random_path();
      end

      // full pause of the sender, then swap the idle patterns
      drain_responses();
      req_idle_pct = 58;
      rsp_idle_pct = 16;
      while (items_in < PhaseBEnd) begin
         send_random_path();
      end

      // no idling; the long receiver hold-off lands in this stretch
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (items_in < TotalItems) begin
         send_random_path();
      end

      drain_responses();
      if (mismatch_count == 0 && cleaned_path_q.size() == 0) begin
         $display("** url_path_normalizer_core: PASSED **");
      end else begin
         $display("** url_path_normalizer_core: FAILED **");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // response side
   // -------------------------------------------------------------------------

   // receiver ready, with one long hold-off so the block backs up into the input
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_in >= HoldAt) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (reset || hold_left > 0) begin
            if (hold_left > 0) begin
               hold_left--;
            end
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic note_mismatch(input string what, input path_result_t want,
                                input path_result_t got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch (%s): expected byte %h present %b last %b accepted %b,",
                  what, want.data, want.present, want.last, want.acc);
         $display("   got byte %h present %b last %b accepted %b",
                  got.data, got.present, got.last, got.acc);
      end
   endtask

   // every accepted response transaction against the oldest expectation
   always @(posedge clock) begin
      path_result_t got;
      path_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{data: rsp_tdata, present: rsp_tuser[0], last: rsp_tlast,
                 acc: rsp_tuser[1]};
         if (cleaned_path_q.size() == 0) begin
            note_mismatch("unexpected transaction", NO_RESULT, got);
         end else begin
            want = cleaned_path_q.pop_front();
            if (got.data !== want.data || got.present !== want.present ||
                got.last !== want.last || got.acc !== want.acc) begin
               note_mismatch("field", want, got);
            end
         end
      end
   end

   // hard stop in case a handshake never completes
   initial begin
      #TimeoutUnits;
      $display("** url_path_normalizer_core: FAILED **");
      $finish;
   end

endmodule
